// File: design/ptbc_pkg.sv
// ----------------------------------------------------------------------------
// ptbc_pkg
// shared widths, microcode types and the control program of the pid
// throttle and brake controller
// ----------------------------------------------------------------------------
package ptbc_pkg;

  // time step is 2^-TIME_STEP_SHIFT
  localparam int TIME_STEP_SHIFT = 6;
  localparam int THR_DEADBAND    = 41;
  localparam int BRK_DEADBAND    = 41;

  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 16;
  localparam int DE_W    = ERR_W + 1;
  localparam int INTEG_W = 40;
  localparam int SPLIT   = 20;                 // low half of the integrator operand
  localparam int OPND_W  = INTEG_W - SPLIT + 1; // signed multiplier operand
  localparam int PROD_W  = GAIN_W + 1 + OPND_W;
  localparam int ACC_W   = 58;
  localparam int LIM_SH  = 4 + TIME_STEP_SHIFT; // Q4.12 limit to product scale
  localparam int CMD_W   = 13;
  localparam logic [CMD_W-1:0] CMD_FULL = 13'd4096;
  localparam int ONE_Q16 = 65536;

  localparam int STEP_W    = 4;
  localparam int NUM_STEPS = 15;

  typedef enum logic [2:0] {
    CFG_KP_THROTTLE = 3'd0,
    CFG_KI_THROTTLE = 3'd1,
    CFG_KD_THROTTLE = 3'd2,
    CFG_KP_BRAKE    = 3'd3,
    CFG_KI_BRAKE    = 3'd4,
    CFG_KD_BRAKE    = 3'd5,
    CFG_SEP_THROTTLE = 3'd6,
    CFG_SEP_BRAKE   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_t;
    logic [GAIN_W-1:0] ki_t;
    logic [GAIN_W-1:0] kd_t;
    logic [GAIN_W-1:0] kp_b;
    logic [GAIN_W-1:0] ki_b;
    logic [GAIN_W-1:0] kd_b;
    logic [GAIN_W-1:0] sep_t;
    logic [GAIN_W-1:0] sep_b;
  } gains_t;

  // multiplier gain select; KPS picks the side by the sign of the error
  typedef enum logic [2:0] {
    G_KPS, G_KIB, G_KPB, G_KDB, G_KIT, G_KPT, G_KDT
  } gain_sel_e;

  typedef enum logic [2:0] {
    O_TRL_LO, O_TRL_HI, O_INT_LO, O_INT_HI, O_ERR, O_DE
  } opnd_sel_e;

  // accumulator works on the product registered in the previous step
  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LOAD,     // acc = prod
    ACC_ADD_HI,   // acc += prod << SPLIT
    ACC_ASR_ADD,  // acc = floor(acc >> TIME_STEP_SHIFT) + prod
    ACC_ADD_D,    // acc += prod << TIME_STEP_SHIFT
    ACC_NEG_LOAD  // brake sum = -acc, acc = prod
  } acc_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_SKIP_FAIL, // jump to target when the separation test fails
    SEQ_FINISH     // hand over the result, wait while the output is held
  } seq_op_e;

  typedef struct packed {
    gain_sel_e         gsel;
    opnd_sel_e         osel;
    acc_op_e           acc_op;
    logic              integ_wr;
    seq_op_e           seq_op;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{gsel: G_KPS, osel: O_ERR, acc_op: ACC_NOP,
                                  integ_wr: 1'b0, seq_op: SEQ_NEXT, target: '0};

  function automatic ctrl_t cw(input gain_sel_e g, input opnd_sel_e o, input acc_op_e a,
                               input logic w, input seq_op_e s,
                               input logic [STEP_W-1:0] t);
    ctrl_t c;
    c.gsel     = g;
    c.osel     = o;
    c.acc_op   = a;
    c.integ_wr = w;
    c.seq_op   = s;
    c.target   = t;
    return c;
  endfunction

  // control program
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    unique case (step)
      // separation test: kp * trial against the limit, then the integrator update
      4'd0:  c = cw(G_KPS, O_TRL_LO, ACC_NOP,      1'b0, SEQ_NEXT,      '0);
      4'd1:  c = cw(G_KPS, O_TRL_HI, ACC_LOAD,     1'b0, SEQ_NEXT,      '0);
      4'd2:  c = cw(G_KPS, O_ERR,    ACC_ADD_HI,   1'b0, SEQ_NEXT,      '0);
      4'd3:  c = cw(G_KPS, O_ERR,    ACC_NOP,      1'b0, SEQ_SKIP_FAIL, 4'd5);
      4'd4:  c = cw(G_KPS, O_ERR,    ACC_NOP,      1'b1, SEQ_NEXT,      '0);
      // brake sum
      4'd5:  c = cw(G_KIB, O_INT_LO, ACC_NOP,      1'b0, SEQ_NEXT,      '0);
      4'd6:  c = cw(G_KIB, O_INT_HI, ACC_LOAD,     1'b0, SEQ_NEXT,      '0);
      4'd7:  c = cw(G_KPB, O_ERR,    ACC_ADD_HI,   1'b0, SEQ_NEXT,      '0);
      4'd8:  c = cw(G_KDB, O_DE,     ACC_ASR_ADD,  1'b0, SEQ_NEXT,      '0);
      4'd9:  c = cw(G_KIT, O_INT_LO, ACC_ADD_D,    1'b0, SEQ_NEXT,      '0);
      // throttle sum
      4'd10: c = cw(G_KIT, O_INT_HI, ACC_NEG_LOAD, 1'b0, SEQ_NEXT,      '0);
      4'd11: c = cw(G_KPT, O_ERR,    ACC_ADD_HI,   1'b0, SEQ_NEXT,      '0);
      4'd12: c = cw(G_KDT, O_DE,     ACC_ASR_ADD,  1'b0, SEQ_NEXT,      '0);
      4'd13: c = cw(G_KDT, O_DE,     ACC_ADD_D,    1'b0, SEQ_NEXT,      '0);
      4'd14: c = cw(G_KDT, O_DE,     ACC_NOP,      1'b0, SEQ_FINISH,    '0);
      default: c = cw(G_KDT, O_DE,   ACC_NOP,      1'b0, SEQ_FINISH,    '0);
    endcase
    return c;
  endfunction

endpackage

// File: design/pid_throttle_brake_controller.sv
// ----------------------------------------------------------------------------
// pid_throttle_brake_controller
// pid speed controller with integral separation giving throttle and brake
// ----------------------------------------------------------------------------
// the result is registered in the output register when the finish step runs; the update
//   step is skipped when the separation test refuses the trial integral
// a new item is taken only after the previous one has run the 15-step control program,
//   which runs every product through one shared 17 x 21 bit multiplier
// the finish step waits while the output register holds a result that is not taken
// reset clears the integrator and the previous error and loads the default gains
// ----------------------------------------------------------------------------
module pid_throttle_brake_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] speed_error
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [12:0] throttle_cmd, [25:13] brake_cmd, rest zero
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int CMD_W = ptbc_pkg::CMD_W;

  ptbc_pkg::gains_t   gains_q;
  ptbc_pkg::ctrl_t    ctrl;
  logic               busy;
  logic               done;
  logic               start;
  logic               sep_fail;
  logic               out_hold;
  logic [CMD_W-1:0]   throttle, brake;

  logic               out_valid_q;
  logic [CMD_W-1:0]   out_thr_q, out_brk_q;

  // a new item is taken whenever the sequencer is not running
  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;

  // finish step waits while an earlier result is still not taken
  assign out_hold = out_valid_q && !m_axis_tready;

  // configuration registers, reset to the default tuning
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp_t  <= 16'd256;
      gains_q.ki_t  <= 16'd0;
      gains_q.kd_t  <= 16'd0;
      gains_q.kp_b  <= 16'd256;
      gains_q.ki_b  <= 16'd0;
      gains_q.kd_b  <= 16'd0;
      gains_q.sep_t <= 16'd4096;
      gains_q.sep_b <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (ptbc_pkg::cfg_idx_e'(cfg_idx_i))
        ptbc_pkg::CFG_KP_THROTTLE:  gains_q.kp_t  <= cfg_wdata_i;
        ptbc_pkg::CFG_KI_THROTTLE:  gains_q.ki_t  <= cfg_wdata_i;
        ptbc_pkg::CFG_KD_THROTTLE:  gains_q.kd_t  <= cfg_wdata_i;
        ptbc_pkg::CFG_KP_BRAKE:     gains_q.kp_b  <= cfg_wdata_i;
        ptbc_pkg::CFG_KI_BRAKE:     gains_q.ki_b  <= cfg_wdata_i;
        ptbc_pkg::CFG_KD_BRAKE:     gains_q.kd_b  <= cfg_wdata_i;
        ptbc_pkg::CFG_SEP_THROTTLE: gains_q.sep_t <= cfg_wdata_i;
        ptbc_pkg::CFG_SEP_BRAKE:    gains_q.sep_b <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // step counter and control store
  ptbc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .sep_fail_i (sep_fail),
    .out_hold_i (out_hold),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .done_o     (done)
  );

  // multiplier, accumulator, integrator and output shaping
  ptbc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .err_i      ($signed(s_axis_tdata)),
    .ctrl_i     (ctrl),
    .gains_i    (gains_q),
    .sep_fail_o (sep_fail),
    .throttle_o (throttle),
    .brake_o    (brake)
  );

  // output register parts the sequencer from the result side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_thr_q <= throttle;
      out_brk_q <= brake;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_brk_q, out_thr_q};

endmodule

// File: design/ptbc_seq.sv
// ----------------------------------------------------------------------------
// ptbc_seq
// step counter and control store of the controller
// ----------------------------------------------------------------------------
module ptbc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            sep_fail_i,
  input  logic            out_hold_i,
  output ptbc_pkg::ctrl_t ctrl_o,
  output logic            busy_o,
  output logic            done_o
);

  logic                          busy_q, busy_d;
  logic [ptbc_pkg::STEP_W-1:0]   step_q, step_d;
  ptbc_pkg::ctrl_t               word;

  assign word   = ptbc_pkg::ucode(step_q);
  assign ctrl_o = busy_q ? word : ptbc_pkg::CTRL_IDLE;
  assign busy_o = busy_q;
  assign done_o = busy_q && (word.seq_op == ptbc_pkg::SEQ_FINISH) && !out_hold_i;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else begin
      unique case (word.seq_op)
        ptbc_pkg::SEQ_NEXT: begin
          step_d = step_q + 1'b1;
        end
        ptbc_pkg::SEQ_SKIP_FAIL: begin
          step_d = sep_fail_i ? word.target : step_q + 1'b1;
        end
        ptbc_pkg::SEQ_FINISH: begin
          if (!out_hold_i) begin
            busy_d = 1'b0;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // program counter stays inside the program
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (32'(step_q) < ptbc_pkg::NUM_STEPS))
    else $error("step counter ran past the program");

  // a start enters step zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> (busy_q && step_q == '0))
    else $error("start did not enter the program");

  // handing over the result ends the run
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q)
    else $error("sequencer still busy after finish");

  // integrator is written only by the update step
  a_integ_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.integ_wr |-> (busy_q && $past(step_q) == 4'd3 && !$past(sep_fail_i)))
    else $error("integrator written outside its step");

endmodule

// File: design/ptbc_dp.sv
// ----------------------------------------------------------------------------
// ptbc_dp
// datapath: shared gain multiplier, accumulator, integrator and shaping
// ----------------------------------------------------------------------------
module ptbc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ptbc_pkg::ERR_W-1:0]  err_i,
  input  ptbc_pkg::ctrl_t                    ctrl_i,
  input  ptbc_pkg::gains_t                   gains_i,
  output logic                               sep_fail_o,
  output logic [ptbc_pkg::CMD_W-1:0]         throttle_o,
  output logic [ptbc_pkg::CMD_W-1:0]         brake_o
);

  localparam int ERR_W   = ptbc_pkg::ERR_W;
  localparam int DE_W    = ptbc_pkg::DE_W;
  localparam int INTEG_W = ptbc_pkg::INTEG_W;
  localparam int SPLIT   = ptbc_pkg::SPLIT;
  localparam int OPND_W  = ptbc_pkg::OPND_W;
  localparam int PROD_W  = ptbc_pkg::PROD_W;
  localparam int ACC_W   = ptbc_pkg::ACC_W;
  localparam int GAIN_W  = ptbc_pkg::GAIN_W;
  localparam int CMD_W   = ptbc_pkg::CMD_W;
  localparam int TSS     = ptbc_pkg::TIME_STEP_SHIFT;
  localparam int LIM_SH  = ptbc_pkg::LIM_SH;

  localparam logic signed [ACC_W-1:0] DZ_THR_T = ACC_W'(ptbc_pkg::THR_DEADBAND * 16);
  localparam logic signed [ACC_W-1:0] DZ_THR_B = ACC_W'(ptbc_pkg::BRK_DEADBAND * 16);
  localparam logic signed [ACC_W-1:0] ONE_ACC  = ACC_W'(ptbc_pkg::ONE_Q16);

  // state
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_q;
  // per-tick registers
  logic signed [ERR_W-1:0]   err_q;
  logic                      err_pos_q;
  logic signed [DE_W-1:0]    de_q;
  logic signed [INTEG_W-1:0] trial_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   brk_q;

  logic signed [INTEG_W:0]   sum_wide;
  logic signed [INTEG_W-1:0] trial_d;
  logic signed [DE_W-1:0]    de_d;
  logic [GAIN_W-1:0]         gain;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   lim;
  logic                      brk_pos;

  // trial integral, saturated to the integrator range
  assign sum_wide = {integ_q[INTEG_W-1], integ_q}
                  + {{(INTEG_W + 1 - ERR_W){err_i[ERR_W-1]}}, err_i};
  always_comb begin
    if (sum_wide[INTEG_W] != sum_wide[INTEG_W-1]) begin
      trial_d = sum_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                  : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      trial_d = sum_wide[INTEG_W-1:0];
    end
  end

  assign de_d = {err_i[ERR_W-1], err_i} - {prev_q[ERR_W-1], prev_q};

  always_comb begin
    unique case (ctrl_i.gsel)
      ptbc_pkg::G_KPS: gain = err_pos_q ? gains_i.kp_t : gains_i.kp_b;
      ptbc_pkg::G_KIB: gain = gains_i.ki_b;
      ptbc_pkg::G_KPB: gain = gains_i.kp_b;
      ptbc_pkg::G_KDB: gain = gains_i.kd_b;
      ptbc_pkg::G_KIT: gain = gains_i.ki_t;
      ptbc_pkg::G_KPT: gain = gains_i.kp_t;
      ptbc_pkg::G_KDT: gain = gains_i.kd_t;
      default:         gain = '0;
    endcase
  end

  // lower halves enter as positive values, upper halves carry the sign
  always_comb begin
    unique case (ctrl_i.osel)
      ptbc_pkg::O_TRL_LO: opnd = {1'b0, trial_q[SPLIT-1:0]};
      ptbc_pkg::O_TRL_HI: opnd = {trial_q[INTEG_W-1], trial_q[INTEG_W-1:SPLIT]};
      ptbc_pkg::O_INT_LO: opnd = {1'b0, integ_q[SPLIT-1:0]};
      ptbc_pkg::O_INT_HI: opnd = {integ_q[INTEG_W-1], integ_q[INTEG_W-1:SPLIT]};
      ptbc_pkg::O_ERR:    opnd = {{(OPND_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      ptbc_pkg::O_DE:     opnd = {{(OPND_W-DE_W){de_q[DE_W-1]}}, de_q};
      default:            opnd = '0;
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    unique case (ctrl_i.acc_op)
      ptbc_pkg::ACC_NOP:      acc_d = acc_q;
      ptbc_pkg::ACC_LOAD:     acc_d = prod_ext;
      ptbc_pkg::ACC_ADD_HI:   acc_d = acc_q + (prod_ext <<< SPLIT);
      ptbc_pkg::ACC_ASR_ADD:  acc_d = (acc_q >>> TSS) + prod_ext;
      ptbc_pkg::ACC_ADD_D:    acc_d = acc_q + (prod_ext <<< TSS);
      ptbc_pkg::ACC_NEG_LOAD: acc_d = prod_ext;
      default:                acc_d = acc_q;
    endcase
  end

  // separation limit scaled to the product
  assign lim = {{(ACC_W - GAIN_W - LIM_SH){1'b0}},
                (err_pos_q ? gains_i.sep_t : gains_i.sep_b), {LIM_SH{1'b0}}};
  assign sep_fail_o = err_pos_q ? (acc_q > lim) : (acc_q < -lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      if (start_i) begin
        prev_q <= err_i;
      end
      if (ctrl_i.integ_wr) begin
        integ_q <= trial_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      err_q     <= err_i;
      err_pos_q <= !err_i[ERR_W-1] && (err_i != '0);
      de_q      <= de_d;
      trial_q   <= trial_d;
    end
    prod_q <= $signed({1'b0, gain}) * opnd;
    acc_q  <= acc_d;
    if (ctrl_i.acc_op == ptbc_pkg::ACC_NEG_LOAD) begin
      brk_q <= -acc_q;
    end
  end

  function automatic logic [CMD_W-1:0] shape(input logic signed [ACC_W-1:0] a,
                                             input logic signed [ACC_W-1:0] thr);
    logic [CMD_W-1:0] r;
    if (a < thr) begin
      r = '0;
    end else if (a > ONE_ACC) begin
      r = ptbc_pkg::CMD_FULL;
    end else begin
      r = a[CMD_W+3:4];
    end
    return r;
  endfunction

  // accumulator holds the throttle sum at the finish step
  assign brk_pos    = !brk_q[ACC_W-1] && (brk_q != '0);
  assign brake_o    = shape(brk_q, DZ_THR_B);
  assign throttle_o = brk_pos ? '0 : shape(acc_q, DZ_THR_T);

endmodule
